@@ rtl/core/stset_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stset_pkg: shared types and constants of the sorted tag set
// Command codes, controller states, cell operations and the transaction
// structs of the command and result channels.
// ----------------------------------------------------------------------------
package stset_pkg;

  localparam int DEF_CAPACITY   = 64;
  localparam int DEF_INDEX_BITS = 16;
  localparam int CMD_W          = 3;
  localparam int ITEM_W         = 16;
  localparam int COUNT_W        = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_ISHIFT = 3'd3,
    CMD_DSHIFT = 3'd4,
    CMD_CLEAR  = 3'd5
  } stset_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } stset_state_t;

  // What every cell at or above the insertion point does in the update cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_REM,
    CELL_REM_DEC,
    CELL_DEC,
    CELL_INC
  } stset_cell_op_t;

  typedef struct packed {
    logic           cmp_en;
    stset_cell_op_t op;
  } stset_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ITEM_W-1:0] item_index;
  } stset_in_t;

  typedef struct packed {
    logic               was_tagged;
    logic [COUNT_W-1:0] tag_count;
    logic               rejected;
  } stset_out_t;

endpackage

@@ rtl/core/sorted_tag_set.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_tag_set: sorted, duplicate-free set of item indices
// A row of cells keeps the entries in order; a small controller runs each
// command through a compare cycle and an update cycle.
//
//   channel  ports                    direction  handshake
//   command  start, busy, in_data     in         start high while busy low
//   result   out_valid, out_data      out        one-cycle strobe, no stall
//
// Every command passes through capture, a compare in every cell, and the
// update of every cell together with the count. The result strobes in the
// cycle after the update, and a new command may be accepted in that cycle.
// Reset is synchronous and empties the set through the count alone; there
// is no clearing pass. The result channel cannot be held off.
// ----------------------------------------------------------------------------
module sorted_tag_set #(
  parameter int CAPACITY   = stset_pkg::DEF_CAPACITY,
  parameter int INDEX_BITS = stset_pkg::DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  stset_pkg::stset_in_t  in_data,
  output logic                  out_valid,
  output stset_pkg::stset_out_t out_data
);

  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = stset_pkg::COUNT_W;

  stset_pkg::stset_state_t state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [stset_pkg::CMD_W-1:0] cmd_r;
  logic [INDEX_BITS-1:0]   key_r;
  logic                    out_valid_r;
  stset_pkg::stset_out_t   out_r, out_nxt;
  stset_pkg::stset_ctl_t   ctl;
  logic                    accept;

  logic [INDEX_BITS-1:0]   entry_w [CAPACITY];
  logic [CAPACITY-1:0]     lt_w, eq_w, max_w, valid_w;
  logic                    present, any_max, full;

  assign accept = start && (state_r == stset_pkg::ST_IDLE);
  assign busy   = (state_r != stset_pkg::ST_IDLE);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign valid_w[i] = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_first
      stset_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
        .clk(clk), .ctl(ctl), .key(key_r), .valid(valid_w[i]),
        .left_entry(key_r), .left_lt(1'b1),
        .right_entry((CAPACITY > 1) ? entry_w[(CAPACITY > 1) ? 1 : 0] : entry_w[0]),
        .entry(entry_w[i]), .lt(lt_w[i]), .eq_hit(eq_w[i]), .max_hit(max_w[i])
      );
    end else if (i == CAPACITY - 1) begin : g_last
      stset_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
        .clk(clk), .ctl(ctl), .key(key_r), .valid(valid_w[i]),
        .left_entry(entry_w[i-1]), .left_lt(lt_w[i-1]),
        .right_entry(entry_w[i]),
        .entry(entry_w[i]), .lt(lt_w[i]), .eq_hit(eq_w[i]), .max_hit(max_w[i])
      );
    end else begin : g_mid
      stset_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
        .clk(clk), .ctl(ctl), .key(key_r), .valid(valid_w[i]),
        .left_entry(entry_w[i-1]), .left_lt(lt_w[i-1]),
        .right_entry(entry_w[i+1]),
        .entry(entry_w[i]), .lt(lt_w[i]), .eq_hit(eq_w[i]), .max_hit(max_w[i])
      );
    end
  end

  assign present = |eq_w;
  // Entries are sorted and unique, so a valid entry at the maximum index is
  // necessarily the last one and lies at or above any key.
  assign any_max = |max_w;
  assign full    = (count_r >= CNT_W'(CAPACITY));

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ctl.cmp_en = 1'b0;
    ctl.op     = stset_pkg::CELL_HOLD;
    out_nxt    = out_r;
    case (state_r)
      stset_pkg::ST_IDLE: begin
        if (start) state_nxt = stset_pkg::ST_CMP;
      end
      stset_pkg::ST_CMP: begin
        ctl.cmp_en = 1'b1;
        state_nxt  = stset_pkg::ST_UPD;
      end
      stset_pkg::ST_UPD: begin
        state_nxt          = stset_pkg::ST_IDLE;
        out_nxt.rejected   = 1'b0;
        out_nxt.was_tagged = present;
        case (cmd_r)
          stset_pkg::CMD_ADD: begin
            if (!present) begin
              if (full) begin
                out_nxt.rejected = 1'b1;
              end else begin
                ctl.op    = stset_pkg::CELL_INS;
                count_nxt = count_r + CNT_W'(1);
              end
            end
          end
          stset_pkg::CMD_REMOVE: begin
            if (present) begin
              ctl.op    = stset_pkg::CELL_REM;
              count_nxt = count_r - CNT_W'(1);
            end
          end
          stset_pkg::CMD_DSHIFT: begin
            if (present) begin
              ctl.op    = stset_pkg::CELL_REM_DEC;
              count_nxt = count_r - CNT_W'(1);
            end else begin
              ctl.op = stset_pkg::CELL_DEC;
            end
          end
          stset_pkg::CMD_ISHIFT: begin
            ctl.op = stset_pkg::CELL_INC;
            if (any_max) count_nxt = count_r - CNT_W'(1);
          end
          stset_pkg::CMD_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
        out_nxt.tag_count = OUT_CNT_W'(count_nxt);
      end
      default: state_nxt = stset_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stset_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == stset_pkg::ST_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.command;
      key_r <= INDEX_BITS'(in_data.item_index);
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted command produced no result");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while a command is in flight");

  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.rejected) |-> (count_r == CNT_W'(CAPACITY)))
    else $error("add rejected although the set was not full");
`endif

endmodule

@@ rtl/core/stset_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stset_cell: one slot of the sorted tag set
// Holds one entry, compares it with the key and, in the update cycle, takes
// a value from itself, a neighbour or the key, as the command requires.
// ----------------------------------------------------------------------------
module stset_cell #(
  parameter int INDEX_BITS = stset_pkg::DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  stset_pkg::stset_ctl_t ctl,
  input  logic [INDEX_BITS-1:0] key,
  input  logic                  valid,
  input  logic [INDEX_BITS-1:0] left_entry,
  input  logic                  left_lt,
  input  logic [INDEX_BITS-1:0] right_entry,
  output logic [INDEX_BITS-1:0] entry,
  output logic                  lt,
  output logic                  eq_hit,
  output logic                  max_hit
);

  logic [INDEX_BITS-1:0] entry_r, entry_nxt;
  logic                  lt_r, eq_r, max_r;
  logic                  ge;

  assign ge = !lt_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ge) begin
      case (ctl.op)
        stset_pkg::CELL_HOLD:    entry_nxt = entry_r;
        // The slot at the insertion point takes the key, the rest move up.
        stset_pkg::CELL_INS:     entry_nxt = left_lt ? key : left_entry;
        stset_pkg::CELL_REM:     entry_nxt = right_entry;
        stset_pkg::CELL_REM_DEC: entry_nxt = right_entry - INDEX_BITS'(1);
        stset_pkg::CELL_DEC:     entry_nxt = entry_r - INDEX_BITS'(1);
        stset_pkg::CELL_INC:     entry_nxt = entry_r + INDEX_BITS'(1);
        default:                 entry_nxt = entry_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt_r  <= valid && (entry_r < key);
      eq_r  <= valid && (entry_r == key);
      max_r <= valid && (entry_r == {INDEX_BITS{1'b1}});
    end
    entry_r <= entry_nxt;
  end

  assign entry   = entry_r;
  assign lt      = lt_r;
  assign eq_hit  = eq_r;
  assign max_hit = max_r;

endmodule

@@ dv/sorted_tag_set_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_tag_set_tb: self-checking testbench of the sorted tag set
// A scoreboard keeps its own sorted copy of the set and predicts every
// result. The stimulus starts with a short directed run over the corner
// cases. Random blocks follow: fill runs to capacity, renumbering runs near
// both ends of the index range, mixed traffic and noise. The sender idles
// at different rates from one phase to the next.
// ----------------------------------------------------------------------------
module sorted_tag_set_tb;

  localparam int CAP = stset_pkg::DEF_CAPACITY;
  localparam int IDX_W = stset_pkg::DEF_INDEX_BITS;
  localparam int ITEM_W = stset_pkg::ITEM_W;
  localparam int CMD_W = stset_pkg::CMD_W;
  localparam int COUNT_W = stset_pkg::COUNT_W;
  localparam logic [ITEM_W-1:0] MAX_INDEX = 16'hFFFF;
  // Command codes outside the defined set; the block must leave the set alone.
  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
  localparam int ITEMS_PER_PHASE = 440;
  localparam int DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    PAT_FILL,
    PAT_MIX,
    PAT_SHIFT,
    PAT_NOISE
  } stim_pat_t;

  class tag_scoreboard;
    logic [ITEM_W-1:0] tags [CAP];
    int n_tags;
    stset_pkg::stset_out_t expected_q [$];
    int unsigned errors, n_results, n_commands, n_full, n_rejects, n_drops, n_hits;

    function new();
      n_tags = 0;
      errors = 0;
      n_results = 0;
      n_commands = 0;
      n_full = 0;
      n_rejects = 0;
      n_drops = 0;
      n_hits = 0;
    endfunction

    // Applies one accepted transaction to the shadow set and queues its result.
    function void note_command(stset_pkg::stset_in_t c);
      int pos;
      int i;
      logic [ITEM_W-1:0] key;
      bit hit;
      bit rej;
      stset_pkg::stset_out_t res;
      key = c.item_index;
      rej = 1'b0;
      pos = 0;
      while (pos < n_tags && tags[pos] < key) pos++;
      hit = (pos < n_tags) && (tags[pos] == key);
      n_commands++;
      if (n_tags == CAP) n_full++;
      if (hit) n_hits++;
      case (c.command)
        stset_pkg::CMD_ADD: begin
          if (!hit) begin
            if (n_tags >= CAP) begin
              rej = 1'b1;
              n_rejects++;
            end else begin
              for (i = n_tags; i > pos; i--) tags[i] = tags[i-1];
              tags[pos] = key;
              n_tags++;
            end
          end
        end
        stset_pkg::CMD_REMOVE, stset_pkg::CMD_DSHIFT: begin
          if (hit) begin
            for (i = pos; i + 1 < n_tags; i++) tags[i] = tags[i+1];
            n_tags--;
          end
          if (c.command == stset_pkg::CMD_DSHIFT) begin
            for (i = pos; i < n_tags; i++) tags[i] = tags[i] - 16'd1;
          end
        end
        stset_pkg::CMD_ISHIFT: begin
          // The top entry cannot move past the largest index and falls out.
          if (n_tags > 0 && pos < n_tags && tags[n_tags-1] == MAX_INDEX) begin
            n_tags--;
            n_drops++;
          end
          for (i = pos; i < n_tags; i++) tags[i] = tags[i] + 16'd1;
        end
        stset_pkg::CMD_CLEAR: n_tags = 0;
        stset_pkg::CMD_QUERY: ;
        default: ;
      endcase
      res.was_tagged = hit;
      res.tag_count = n_tags[COUNT_W-1:0];
      res.rejected = rej;
      expected_q.push_back(res);
    endfunction

    function void check_result(stset_pkg::stset_out_t r);
      stset_pkg::stset_out_t exp;
      n_results++;
      if (expected_q.size() == 0) begin
        $error("result with no transaction outstanding: %p", r);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (r.was_tagged !== exp.was_tagged) begin
        $error("was_tagged: expected %0d, actual %0d", exp.was_tagged, r.was_tagged);
        errors++;
      end
      if (r.tag_count !== exp.tag_count) begin
        $error("tag_count: expected %0d, actual %0d", exp.tag_count, r.tag_count);
        errors++;
      end
      if (r.rejected !== exp.rejected) begin
        $error("rejected: expected %0d, actual %0d", exp.rejected, r.rejected);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    function logic [ITEM_W-1:0] random_tag();
      if (n_tags == 0) return ITEM_W'($urandom_range(MAX_INDEX));
      return tags[$urandom_range(n_tags - 1)];
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  stset_pkg::stset_in_t in_data;
  logic out_valid;
  stset_pkg::stset_out_t out_data;

  tag_scoreboard sb;
  int idle_pct;
  int fill_k;
  int sent;
  int block_len;
  stim_pat_t pat;
  logic [ITEM_W-1:0] fill_base;
  int fill_stride;
  bit fill_top;
  stset_pkg::stset_in_t cmd;
  int phase_idle [4] = '{0, 85, 36, 0};

  always #4 clk = ~clk;

  sorted_tag_set #(
    .CAPACITY  (CAP),
    .INDEX_BITS(IDX_W)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // Results are checked before the new transaction of the same edge is noted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_data);
      if (start && !busy) sb.note_command(in_data);
    end
  end

  function automatic stset_pkg::stset_in_t mk(logic [CMD_W-1:0] op,
                                              logic [ITEM_W-1:0] idx);
    stset_pkg::stset_in_t c;
    c.command = op;
    c.item_index = idx;
    return c;
  endfunction

  // Index biased towards entries already held and the ends of the range.
  function automatic logic [ITEM_W-1:0] near_index();
    case ($urandom_range(9))
      0: return '0;
      1: return MAX_INDEX;
      2: return MAX_INDEX - ITEM_W'($urandom_range(3));
      3, 4, 5: return sb.random_tag();
      6, 7: return sb.random_tag() + ITEM_W'($urandom_range(2)) - 16'd1;
      default: return ITEM_W'($urandom_range(MAX_INDEX));
    endcase
  endfunction

  function automatic stset_pkg::stset_in_t next_fill();
    logic [ITEM_W-1:0] idx;
    int r;
    r = $urandom_range(99);
    if (r < 75) begin
      idx = fill_top ? MAX_INDEX - ITEM_W'(fill_k * fill_stride)
                     : fill_base + ITEM_W'(fill_k * fill_stride);
      fill_k++;
      return mk(stset_pkg::CMD_ADD, idx);
    end
    if (r < 85) return mk(stset_pkg::CMD_ADD, sb.random_tag());
    if (r < 93) return mk(stset_pkg::CMD_QUERY, near_index());
    return mk(stset_pkg::CMD_REMOVE, near_index());
  endfunction

  function automatic stset_pkg::stset_in_t next_mix();
    int r;
    r = $urandom_range(99);
    if (r < 30) return mk(stset_pkg::CMD_ADD, near_index());
    if (r < 46) return mk(stset_pkg::CMD_REMOVE, near_index());
    if (r < 62) return mk(stset_pkg::CMD_QUERY, near_index());
    if (r < 76) return mk(stset_pkg::CMD_ISHIFT, near_index());
    if (r < 90) return mk(stset_pkg::CMD_DSHIFT, near_index());
    if (r < 92) return mk(stset_pkg::CMD_CLEAR, near_index());
    if (r < 94) return mk(CMD_RSVD_LO, near_index());
    if (r < 96) return mk(CMD_RSVD_HI, near_index());
    return mk(stset_pkg::CMD_ADD, ITEM_W'($urandom_range(MAX_INDEX)));
  endfunction

  function automatic stset_pkg::stset_in_t next_shift();
    int r;
    r = $urandom_range(99);
    if (r < 40) return mk(stset_pkg::CMD_ISHIFT, near_index());
    if (r < 80) return mk(stset_pkg::CMD_DSHIFT, near_index());
    if (r < 92) return mk(stset_pkg::CMD_ADD, near_index());
    return mk(stset_pkg::CMD_QUERY, near_index());
  endfunction

  task automatic send_cmd(stset_pkg::stset_in_t c);
    start <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap();
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases, run back to back.
    send_cmd(mk(stset_pkg::CMD_QUERY, 16'd0));
    send_cmd(mk(stset_pkg::CMD_ADD, 16'd0));
    send_cmd(mk(stset_pkg::CMD_ADD, MAX_INDEX));
    send_cmd(mk(stset_pkg::CMD_ADD, 16'd0));
    send_cmd(mk(stset_pkg::CMD_ADD, 16'd100));
    send_cmd(mk(stset_pkg::CMD_QUERY, MAX_INDEX));
    send_cmd(mk(stset_pkg::CMD_REMOVE, 16'd5));
    send_cmd(mk(stset_pkg::CMD_ISHIFT, 16'd50));
    send_cmd(mk(stset_pkg::CMD_ISHIFT, 16'd0));
    send_cmd(mk(stset_pkg::CMD_DSHIFT, 16'd1));
    send_cmd(mk(stset_pkg::CMD_DSHIFT, 16'd7));
    send_cmd(mk(stset_pkg::CMD_DSHIFT, 16'd0));
    send_cmd(mk(stset_pkg::CMD_ADD, MAX_INDEX));
    send_cmd(mk(stset_pkg::CMD_ISHIFT, MAX_INDEX));
    send_cmd(mk(stset_pkg::CMD_REMOVE, 16'd99));
    send_cmd(mk(stset_pkg::CMD_DSHIFT, 16'd0));
    send_cmd(mk(stset_pkg::CMD_ISHIFT, 16'd0));
    send_cmd(mk(CMD_RSVD_LO, 16'd0));
    send_cmd(mk(CMD_RSVD_HI, MAX_INDEX));
    send_cmd(mk(stset_pkg::CMD_ADD, MAX_INDEX));
    send_cmd(mk(stset_pkg::CMD_DSHIFT, 16'd0));
    send_cmd(mk(stset_pkg::CMD_ADD, 16'h5555));
    send_cmd(mk(stset_pkg::CMD_CLEAR, 16'hAAAA));
    send_cmd(mk(stset_pkg::CMD_QUERY, 16'd65534));

    // The sender holds off here until the set has answered everything.
    wait_drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6: pat = PAT_FILL;
          7, 8, 9, 10, 11, 12: pat = PAT_MIX;
          13, 14, 15, 16: pat = PAT_SHIFT;
          default: pat = PAT_NOISE;
        endcase
        block_len = (pat == PAT_FILL) ? $urandom_range(70, 110) : $urandom_range(20, 60);
        fill_k = 0;
        fill_top = ($urandom_range(2) == 0);
        fill_base = ITEM_W'($urandom_range(MAX_INDEX));
        fill_stride = ($urandom_range(1) == 0) ? $urandom_range(1, 4) : $urandom_range(1, 900);
        for (int j = 0; j < block_len && sent < ITEMS_PER_PHASE; j++) begin
          case (pat)
            PAT_FILL: cmd = next_fill();
            PAT_MIX: cmd = next_mix();
            PAT_SHIFT: cmd = next_shift();
            default: cmd = mk(CMD_W'($urandom_range(7)), ITEM_W'($urandom_range(MAX_INDEX)));
          endcase
          idle_gap();
          send_cmd(cmd);
          sent++;
        end
      end
      wait_drain();
    end

    if (sb.outstanding() != 0) begin
      $error("%0d results never arrived", sb.outstanding());
      sb.errors++;
    end
    $display("Covered %0d transactions and %0d results; %0d found the index present.",
             sb.n_commands, sb.n_results, sb.n_hits);
    $display("Set at capacity for %0d commands, %0d adds refused, %0d entries shifted out.",
             sb.n_full, sb.n_rejects, sb.n_drops);
    if (sb.errors == 0) begin
      $display("[sorted_tag_set] OK");
    end else begin
      $display("[sorted_tag_set] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[sorted_tag_set] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/stset_pkg.sv
rtl/core/stset_cell.sv
rtl/core/sorted_tag_set.sv
dv/sorted_tag_set_tb.sv
